FILE: design/bf7_pkg.sv
// Shared types and constants for the 7x7 separable box filter.
// No dependencies; used by bf7_out_fifo and box_filter_7x7_separable_top.
`timescale 1ns / 1ps

package bf7_pkg;

  localparam int WIN        = 7;   // horizontal and vertical window size
  localparam int LINE_ROWS  = 6;   // rows of row sums kept in the line store
  localparam int MIN_DIM    = 7;   // smallest effective column or row count
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 11;  // 7 * 255 fits in 11 bits
  localparam int TOTAL_W    = 14;  // 49 * 255 fits in 14 bits
  localparam int SLOT_W     = 3;

  // Divide by 49 as (t * 21400) >> 20, exact for t <= 49 * 255.
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_49 = 15'd21400;

  // Output queue depth; also bounds the words in flight.
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_CNT_W   = 3;

  // Configuration register indexes (paddr[2]).
  localparam logic [0:0] REG_IMAGE_COLS = 1'b0;
  localparam logic [0:0] REG_IMAGE_ROWS = 1'b1;

  localparam logic [10:0] IMAGE_COLS_RST = 11'd512;
  localparam logic [12:0] IMAGE_ROWS_RST = 13'd512;

  typedef struct packed {
    logic             frame_last;
    logic [PIX_W-1:0] smoothed;
  } result_t;

endpackage

FILE: design/bf7_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bf7_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bf7_out_fifo.sv
// Small output queue that decouples the filter pipeline from the master side.
// Depends on bf7_pkg (result_t, OUT_DEPTH, OUT_CNT_W).
`timescale 1ns / 1ps

module bf7_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bf7_pkg::result_t              push_data,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output bf7_pkg::result_t              pop_data,
  output logic [bf7_pkg::OUT_CNT_W-1:0] count
);

  localparam int PTR_W = $clog2(bf7_pkg::OUT_DEPTH);

  bf7_pkg::result_t   entries [bf7_pkg::OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bf7_pkg::OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bf7_pkg::OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/box_filter_7x7_separable_top.sv
// 7x7 separable box filter: running row sums, six-row line store, divide by 49.
// Depends on bf7_pkg, bf7_ram and bf7_out_fifo.
//
// A result passes the stage B and stage C registers and then the output queue
//   before it is shown on m_tvalid.
// Throughput: one pixel per cycle while s_tready is high; the line store takes
//   one read and one write per cycle; a 4-word queue absorbs master-side stalls.
// Reset (rst, synchronous): clears position, pixel window, pipeline and queue,
//   and loads image_cols and image_rows with 512. The line store is not cleared.
`timescale 1ns / 1ps

module box_filter_7x7_separable_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic        s_tuser,   // [0] frame_start
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] smoothed
  output logic        m_tlast,   // frame_last
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int SUM_W  = bf7_pkg::SUM_W;
  localparam int LINE_W = bf7_pkg::LINE_ROWS * SUM_W;
  localparam int PROD_W = bf7_pkg::TOTAL_W + bf7_pkg::RECIP_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] image_cols;
  logic [12:0] image_rows;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= bf7_pkg::IMAGE_COLS_RST;
      image_rows <= bf7_pkg::IMAGE_ROWS_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        bf7_pkg::REG_IMAGE_COLS: image_cols <= pwdata[10:0];
        bf7_pkg::REG_IMAGE_ROWS: image_rows <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bf7_pkg::REG_IMAGE_COLS: prdata = 32'(image_cols);
      bf7_pkg::REG_IMAGE_ROWS: prdata = 32'(image_rows);
      default:                 prdata = '0;
    endcase
  end

  // Saturate the registers into the supported frame size.
  logic [CCNT_W-1:0] cols_eff;
  logic [RCNT_W-1:0] rows_eff;

  always_comb begin
    if (32'(image_cols) < 32'(bf7_pkg::MIN_DIM)) begin
      cols_eff = CCNT_W'(bf7_pkg::MIN_DIM);
    end else if (32'(image_cols) > 32'(MAX_COLS)) begin
      cols_eff = CCNT_W'(MAX_COLS);
    end else begin
      cols_eff = CCNT_W'(image_cols);
    end
    if (32'(image_rows) < 32'(bf7_pkg::MIN_DIM)) begin
      rows_eff = RCNT_W'(bf7_pkg::MIN_DIM);
    end else if (32'(image_rows) > 32'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(image_rows);
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: position tracking, pixel window, horizontal sum, line read
  // ---------------------------------------------------------------------------
  logic                    in_acc;
  logic [COL_W-1:0]        col;
  logic [ROW_W-1:0]        row;
  logic [bf7_pkg::SLOT_W-1:0] slot;
  logic [bf7_pkg::PIX_W-1:0]  pixel_window [bf7_pkg::WIN];

  logic [COL_W-1:0]        c0;
  logic [ROW_W-1:0]        r0;
  logic [bf7_pkg::SLOT_W-1:0] slot0;
  logic [CCNT_W-1:0]       c_inc;
  logic [RCNT_W-1:0]       r_inc;
  logic                    c_wrap;
  logic                    r_wrap;
  logic [COL_W-1:0]        col_next;
  logic [ROW_W-1:0]        row_next;
  logic [bf7_pkg::SLOT_W-1:0] slot_next;
  logic                    in_wr;
  logic                    in_emit;
  logic [SUM_W-1:0]        hsum_in;

  assign in_acc = s_tvalid && s_tready;

  always_comb begin
    // frame_start forces the position of this pixel to the frame origin
    c0     = s_tuser ? '0 : col;
    r0     = s_tuser ? '0 : row;
    slot0  = s_tuser ? '0 : slot;
    c_inc  = CCNT_W'(c0) + 1'b1;
    r_inc  = RCNT_W'(r0) + 1'b1;
    c_wrap = (c_inc >= cols_eff);
    r_wrap = (r_inc >= rows_eff);
    if (!c_wrap) begin
      col_next  = COL_W'(c_inc);
      row_next  = r0;
      slot_next = slot0;
    end else begin
      col_next = '0;
      if (r_wrap) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = ROW_W'(r_inc);
        slot_next = (slot0 == bf7_pkg::SLOT_W'(bf7_pkg::LINE_ROWS - 1)) ? '0 : slot0 + 1'b1;
      end
    end
    // a full row sum exists from column 6 on; a full window from row 6 on
    in_wr   = (32'(c0) >= 32'(bf7_pkg::WIN - 1));
    in_emit = in_wr && (32'(r0) >= 32'(bf7_pkg::WIN - 1));
    // row sum over the window after this pixel shifts in
    hsum_in = SUM_W'(s_tdata);
    for (int i = 1; i < bf7_pkg::WIN; i++) begin
      hsum_in = hsum_in + SUM_W'(pixel_window[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
      for (int i = 0; i < bf7_pkg::WIN; i++) begin
        pixel_window[i] <= '0;
      end
    end else if (in_acc) begin
      col  <= col_next;
      row  <= row_next;
      slot <= slot_next;
      for (int i = 0; i < bf7_pkg::WIN - 1; i++) begin
        pixel_window[i] <= pixel_window[i+1];
      end
      pixel_window[bf7_pkg::WIN-1] <= s_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: line store data returns; add the column, write the new row sum back
  // ---------------------------------------------------------------------------
  logic                       vb;
  logic                       wr_b;
  logic                       emit_b;
  logic                       last_b;
  logic [COL_W-1:0]           col_b;
  logic [bf7_pkg::SLOT_W-1:0] slot_b;
  logic [SUM_W-1:0]           hsum_b;
  logic [LINE_W-1:0]          line_rdata;
  logic [LINE_W-1:0]          line_wdata;
  logic                       line_we;
  logic [bf7_pkg::TOTAL_W-1:0] total_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_b   <= in_wr;
      emit_b <= in_emit;
      last_b <= c_wrap && r_wrap;
      col_b  <= c0;
      slot_b <= slot0;
      hsum_b <= hsum_in;
    end
  end

  // One word holds the six row sums of a column. Consecutive writes of the
  // same column never meet a read of it: the column either advances or wraps
  // to zero, and column zero is never written.
  bf7_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_b),
    .wdata (line_wdata),
    .re    (in_acc),
    .raddr (c0),
    .rdata (line_rdata)
  );

  assign line_we = vb && wr_b;

  always_comb begin
    // the slot of this row still holds the row six above, so all six count
    total_b = bf7_pkg::TOTAL_W'(hsum_b);
    for (int i = 0; i < bf7_pkg::LINE_ROWS; i++) begin
      total_b    = total_b + bf7_pkg::TOTAL_W'(line_rdata[i*SUM_W +: SUM_W]);
      line_wdata[i*SUM_W +: SUM_W] = (slot_b == bf7_pkg::SLOT_W'(i)) ?
                                     hsum_b : line_rdata[i*SUM_W +: SUM_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: divide by 49 through a reciprocal multiply, push into the queue
  // ---------------------------------------------------------------------------
  logic                        vc;
  logic                        emit_c;
  logic                        last_c;
  logic [bf7_pkg::TOTAL_W-1:0] total_c;
  logic [PROD_W-1:0]           prod_c;
  bf7_pkg::result_t            res_c;
  logic                        push;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (vb) begin
      emit_c  <= emit_b;
      last_c  <= last_b;
      total_c <= total_b;
    end
  end

  assign prod_c           = PROD_W'(total_c) * PROD_W'(bf7_pkg::RECIP_49);
  assign res_c.smoothed   = prod_c[bf7_pkg::RECIP_SHIFT +: bf7_pkg::PIX_W];
  assign res_c.frame_last = last_c;
  assign push             = vc && emit_c;

  // ---------------------------------------------------------------------------
  // Output queue; hold off input while in-flight words could overflow it
  // ---------------------------------------------------------------------------
  bf7_pkg::result_t            q_data;
  logic [bf7_pkg::OUT_CNT_W-1:0] q_count;
  logic [bf7_pkg::OUT_CNT_W-1:0] occupancy;

  bf7_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res_c),
    .pop_valid (m_tvalid),
    .pop_ready (m_tready),
    .pop_data  (q_data),
    .count     (q_count)
  );

  assign occupancy = q_count + bf7_pkg::OUT_CNT_W'(vb) + bf7_pkg::OUT_CNT_W'(vc);
  assign s_tready  = (occupancy < bf7_pkg::OUT_CNT_W'(bf7_pkg::OUT_DEPTH));
  assign m_tdata   = q_data.smoothed;
  assign m_tlast   = q_data.frame_last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count < bf7_pkg::OUT_CNT_W'(bf7_pkg::OUT_DEPTH)) || m_tready)
    else $error("output queue overflow");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (line_we && in_acc) |-> (col_b != c0))
    else $error("line store read and write hit the same column");

  a_emit_has_sum: assert property (@(posedge clk) disable iff (rst)
    (vb && emit_b) |-> wr_b)
    else $error("result without a row sum write");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && c_wrap && r_wrap) |=> (col == '0) && (row == '0) && (slot == '0))
    else $error("position not at origin after frame end");
`endif

endmodule
